FILE: hdl/bsi_pkg.sv
package bsi_pkg;

   // field widths fixed by the word formats
   localparam int KEY_W   = 32;
   localparam int PAY_W   = 32;
   localparam int IDX_W   = 6;
   localparam int KEEP_W  = 7;

   // defaults for the top level parameters
   localparam int DEPTH_DEF         = 64;
   localparam int PAYLOAD_WIDTH_DEF = 32;

   // empty entries hold the largest key
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   // request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   typedef struct packed {
      logic                    req_type;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        payload;
      logic [IDX_W-1:0]        read_index;
   } req_word_type;

   typedef struct packed {
      logic                    accepted;
      logic [IDX_W-1:0]        insert_position;
      logic signed [KEY_W-1:0] entry_key;
      logic [PAY_W-1:0]        entry_payload;
   } rsp_word_type;

   // per-cycle command shared by all cells
   typedef struct packed {
      logic insert_en;
      logic rotate_en;
   } cell_ctrl_type;

endpackage

FILE: hdl/bsi_cell.sv
module bsi_cell #(
   parameter int PAYLOAD_WIDTH = bsi_pkg::PAYLOAD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bsi_pkg::cell_ctrl_type          ctrl,
   input  logic                            in_range,
   input  logic signed [bsi_pkg::KEY_W-1:0] new_key,
   input  logic [PAYLOAD_WIDTH-1:0]        new_payload,
   input  logic signed [bsi_pkg::KEY_W-1:0] prev_key,
   input  logic [PAYLOAD_WIDTH-1:0]        prev_payload,
   input  logic                            prev_ge,
   output logic signed [bsi_pkg::KEY_W-1:0] key_q,
   output logic [PAYLOAD_WIDTH-1:0]        payload_q,
   output logic                            ge
);

   logic signed [bsi_pkg::KEY_W-1:0] key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0]         payload_ff, payload_in;

   // this entry is at or above the offered key
   assign ge = (key_ff >= new_key);

   // first entry at or above the key takes it, later kept entries move down
   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ctrl.rotate_en) begin
         key_in     = prev_key;
         payload_in = prev_payload;
      end else if (ctrl.insert_en) begin
         if (ge && !prev_ge) begin
            key_in     = new_key;
            payload_in = new_payload;
         end else if (prev_ge && in_range) begin
            key_in     = prev_key;
            payload_in = prev_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= bsi_pkg::KEY_MAX;
         payload_ff <= '0;
      end else begin
         key_ff     <= key_in;
         payload_ff <= payload_in;
      end
   end

   assign key_q     = key_ff;
   assign payload_q = payload_ff;

endmodule

FILE: hdl/bounded_sorted_insert.sv
// Keeps the keep_count smallest signed keys with their payloads in ascending
// order in a row of DEPTH cells. On an insert every cell compares its key
// with the offered one in parallel and the list shifts down at the insert
// point, so inserts may start in every cycle unless busy, and each result
// word appears with rsp_strobe in the cycle after start. A read rotates the
// whole row once through the last cell and picks the entry as it passes;
// busy is high during the rotation and the result word comes as it ends.
// rsp_strobe is high for exactly one cycle per request; the receiver cannot
// stall it. The user must write keep_count through csr_ only while no
// request is in flight (not enforced); zero acts as one, above DEPTH as DEPTH.
module bounded_sorted_insert #(
   parameter int DEPTH         = bsi_pkg::DEPTH_DEF,
   parameter int PAYLOAD_WIDTH = bsi_pkg::PAYLOAD_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  bsi_pkg::req_word_type       req_word,
   output logic                        rsp_strobe,
   output bsi_pkg::rsp_word_type       rsp_word,
   input  logic                        csr_write_en,
   input  logic [bsi_pkg::KEEP_W-1:0]  csr_write_data
);

   localparam int CNT_W = $clog2(DEPTH);

   logic signed [bsi_pkg::KEY_W-1:0] cell_key [DEPTH];
   logic [PAYLOAD_WIDTH-1:0]         cell_pay [DEPTH];
   logic [DEPTH-1:0]                 ge_vec;
   logic [DEPTH-1:0]                 first_vec;
   logic [DEPTH-1:0]                 last_sel;
   logic [DEPTH-1:0]                 range_vec;

   logic [bsi_pkg::KEEP_W-1:0]       keep_count_ff, eff_keep;
   logic                             busy_ff;
   logic [CNT_W-1:0]                 rd_cnt_ff, rd_target_ff;
   logic                             rd_hit_ff;
   logic signed [bsi_pkg::KEY_W-1:0] rd_key_ff;
   logic [PAYLOAD_WIDTH-1:0]         rd_pay_ff;
   logic                             rsp_strobe_ff;
   bsi_pkg::rsp_word_type            rsp_word_ff, rsp_word_in;

   logic                             ins_go, rd_go, rd_last, rd_now, accepted_c;
   logic [bsi_pkg::IDX_W-1:0]        pos_c;
   logic [PAYLOAD_WIDTH-1:0]         new_pay;
   bsi_pkg::cell_ctrl_type           ctrl;

   // request decode
   assign ins_go  = start && !busy_ff && (req_word.req_type == bsi_pkg::REQ_INSERT);
   assign rd_go   = start && !busy_ff && (req_word.req_type == bsi_pkg::REQ_READ);
   assign rd_last = (rd_cnt_ff == CNT_W'(DEPTH - 1));
   assign rd_now  = (rd_cnt_ff == rd_target_ff);
   assign new_pay = PAYLOAD_WIDTH'(req_word.payload);

   // effective keep count
   always_comb begin
      if (keep_count_ff == '0) begin
         eff_keep = bsi_pkg::KEEP_W'(1);
      end else if (32'(keep_count_ff) > DEPTH) begin
         eff_keep = bsi_pkg::KEEP_W'(DEPTH);
      end else begin
         eff_keep = keep_count_ff;
      end
   end

   assign accepted_c     = |(ge_vec & last_sel);
   assign ctrl.insert_en = ins_go && accepted_c;
   assign ctrl.rotate_en = busy_ff;

   // row of cells, closed into a ring for reads
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [bsi_pkg::KEY_W-1:0] p_key;
      logic [PAYLOAD_WIDTH-1:0]         p_pay;
      logic                             p_ge;

      if (i == 0) begin : g_head
         assign p_key = cell_key[DEPTH-1];
         assign p_pay = cell_pay[DEPTH-1];
         assign p_ge  = 1'b0;
      end else begin : g_body
         assign p_key = cell_key[i-1];
         assign p_pay = cell_pay[i-1];
         assign p_ge  = ge_vec[i-1];
      end

      assign range_vec[i] = (32'(i) < 32'(eff_keep));
      assign last_sel[i]  = (32'(i) == (32'(eff_keep) - 32'd1));
      assign first_vec[i] = ge_vec[i] && !p_ge;

      bsi_cell #(
         .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .in_range    (range_vec[i]),
         .new_key     (req_word.key),
         .new_payload (new_pay),
         .prev_key    (p_key),
         .prev_payload(p_pay),
         .prev_ge     (p_ge),
         .key_q       (cell_key[i]),
         .payload_q   (cell_pay[i]),
         .ge          (ge_vec[i])
      );
   end

   // encode the insert point from its one-hot marker
   always_comb begin
      pos_c = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_vec[i]) begin
            pos_c = pos_c | bsi_pkg::IDX_W'(i);
         end
      end
   end

   // result word
   always_comb begin
      rsp_word_in = '0;
      if (ins_go) begin
         rsp_word_in.accepted        = accepted_c;
         rsp_word_in.insert_position = accepted_c ? pos_c : '0;
      end else if (rd_hit_ff) begin
         rsp_word_in.entry_key     = rd_now ? cell_key[DEPTH-1] : rd_key_ff;
         rsp_word_in.entry_payload = rd_now ? bsi_pkg::PAY_W'(cell_pay[DEPTH-1])
                                            : bsi_pkg::PAY_W'(rd_pay_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= bsi_pkg::KEEP_W'(DEPTH);
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rd_cnt_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            keep_count_ff <= csr_write_data;
         end
         rsp_strobe_ff <= ins_go || (busy_ff && rd_last);
         if (rd_go) begin
            busy_ff   <= 1'b1;
            rd_cnt_ff <= '0;
         end else if (busy_ff) begin
            rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
            if (rd_last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // read bookkeeping and result word
   always_ff @(posedge clock) begin
      if (rd_go) begin
         rd_hit_ff    <= (int'(req_word.read_index) < DEPTH);
         rd_target_ff <= CNT_W'(DEPTH - 1) - CNT_W'(req_word.read_index);
      end
      if (busy_ff && rd_now) begin
         rd_key_ff <= cell_key[DEPTH-1];
         rd_pay_ff <= cell_pay[DEPTH-1];
      end
      if (ins_go || (busy_ff && rd_last)) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // an insert answers in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      ins_go |=> rsp_strobe)
      else $error("insert gave no result word");

   // a read answers when the rotation ends
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> rsp_strobe)
      else $error("read gave no result word");

   // a placed key has exactly one insert point
   assert property (@(posedge clock) disable iff (reset)
      ctrl.insert_en |-> $onehot(first_vec))
      else $error("insert point not unique");

   // the row is in ascending order whenever no rotation is under way
   for (genvar i = 0; i < DEPTH - 1; i++) begin : g_chk
      assert property (@(posedge clock) disable iff (reset)
         !busy_ff |-> (cell_key[i] <= cell_key[i+1]))
         else $error("kept keys out of order");
   end

endmodule
